// ===== rtl/rmmm_pkg.sv =====
package rmmm_pkg;

	// Fixed widths of the channel fields.
	localparam int DATA_BITS = 32;
	localparam int SUM_BITS  = 64;

	// Defaults for the top-level parameters.
	localparam int DEF_SAMPLE_BITS = 32;
	localparam int DEF_COUNT_BITS  = 32;

	// Quotient bits the divider resolves in each cycle.
	localparam int DIV_STEPS_PER_CYCLE = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACT_GO,
		ST_ACT_WAIT,
		ST_TOT_GO,
		ST_TOT_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/rmmm_if.sv =====
interface rmmm_in_if;
	import rmmm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] sample;
	logic                 has_sample;
	logic                 tick;

	modport source (output valid, output sample, output has_sample, output tick, input ready);
	modport sink   (input valid, input sample, input has_sample, input tick, output ready);
endinterface

interface rmmm_out_if;
	import rmmm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] sample_count;
	logic [DATA_BITS-1:0] tick_count;
	logic [SUM_BITS-1:0]  running_sum;
	logic [DATA_BITS-1:0] min_value;
	logic [DATA_BITS-1:0] max_value;
	logic [DATA_BITS-1:0] active_average;
	logic [DATA_BITS-1:0] total_average;
	logic                 has_data;

	modport source (
		output valid, output sample_count, output tick_count, output running_sum,
		output min_value, output max_value, output active_average,
		output total_average, output has_data, input ready
	);
	modport sink (
		input valid, input sample_count, input tick_count, input running_sum,
		input min_value, input max_value, input active_average,
		input total_average, input has_data, output ready
	);
endinterface

// ===== rtl/rmmm_div.sv =====
module rmmm_div #(
	parameter int SAMPLE_BITS = rmmm_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = rmmm_pkg::DEF_COUNT_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rmmm_pkg::div_ctrl_t                   ctrl,
	input  logic signed [rmmm_pkg::SUM_BITS-1:0]  num,
	input  logic        [COUNT_BITS-1:0]          den,
	output rmmm_pkg::div_stat_t                   stat,
	output logic signed [SAMPLE_BITS-1:0]         quot
);
	import rmmm_pkg::*;

	localparam int ACC_BITS  = COUNT_BITS + SUM_BITS;
	localparam int ITERS     = SUM_BITS / DIV_STEPS_PER_CYCLE;
	localparam int ITER_BITS = $clog2(ITERS);
	localparam logic [ITER_BITS-1:0] LAST_ITER = ITER_BITS'(ITERS - 1);
	localparam logic [SUM_BITS-1:0] Q_POS_MAX =
		(SUM_BITS'(1) << (SAMPLE_BITS - 1)) - SUM_BITS'(1);
	localparam logic [SUM_BITS-1:0] Q_NEG_MAX = SUM_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// One restoring step: the remainder sits above the dividend, and quotient
	// bits shift in at the bottom as dividend bits leave at the top.
	function automatic logic [ACC_BITS-1:0] div_step(
		input logic [ACC_BITS-1:0]   acc,
		input logic [COUNT_BITS-1:0] d
	);
		logic [COUNT_BITS:0]   trial;
		logic [COUNT_BITS:0]   diff;
		logic [COUNT_BITS-1:0] rem;
		logic [SUM_BITS-1:0]   wrk;
		logic                  qbit;
		begin
			rem   = acc[ACC_BITS-1:SUM_BITS];
			wrk   = acc[SUM_BITS-1:0];
			trial = {rem, wrk[SUM_BITS-1]};
			diff  = trial - {1'b0, d};
			qbit  = (trial >= {1'b0, d});
			if (qbit) begin
				rem = diff[COUNT_BITS-1:0];
			end else begin
				rem = trial[COUNT_BITS-1:0];
			end
			return {rem, wrk[SUM_BITS-2:0], qbit};
		end
	endfunction

	logic [ACC_BITS-1:0]   acc_q;
	logic [ACC_BITS-1:0]   acc_next;
	logic [COUNT_BITS-1:0] den_q;
	logic                  neg_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ITER_BITS-1:0]  iter_q;
	logic [SUM_BITS-1:0]   num_mag;
	logic [SUM_BITS-1:0]   q;
	logic [SUM_BITS-1:0]   q_neg;

	assign num_mag = num[SUM_BITS-1] ? (SUM_BITS'(0) - num) : num;

	always_comb begin
		acc_next = acc_q;
		for (int i = 0; i < DIV_STEPS_PER_CYCLE; i++) begin
			acc_next = div_step(acc_next, den_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= {{COUNT_BITS{1'b0}}, num_mag};
			den_q <= den;
			neg_q <= num[SUM_BITS-1];
		end else if (busy_q) begin
			acc_q <= acc_next;
		end
	end

	// Truncated magnitude quotient, clamped into the signed sample range.
	assign q     = acc_q[SUM_BITS-1:0];
	assign q_neg = SUM_BITS'(0) - q;

	always_comb begin
		if (neg_q) begin
			quot = (q > Q_NEG_MAX) ? SMP_MIN : q_neg[SAMPLE_BITS-1:0];
		end else begin
			quot = (q > Q_POS_MAX) ? SMP_MAX : q[SAMPLE_BITS-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/running_min_max_mean_unit.sv =====
// Running statistics over signed Q16.16 samples. Each input item may carry a
// sample (has_sample), a time tick (tick), or both, and every item produces
// exactly one stats item taken after that item's updates: sample and tick
// counts (saturating), a saturating 64-bit sum, min and max (most positive and
// most negative until the first sample), the active average sum/sample_count
// and the total average sum/tick_count (0 with no ticks), both truncated toward
// zero and clamped to the sample range. Both averages come from a single
// shared restoring divider that resolves two quotient bits per cycle. An item
// with a sample, once a tick has been counted, runs both divisions before its
// stats item turns valid. While the tick count is still zero a sample item
// skips the total-average division. An item without a sample runs only the
// total-average division, or none at all while the tick count is still zero.
// The block takes no new item until the current one is finished, but a
// finished stats item sits in an output register, so the next item can be
// accepted while the previous result still waits for the sink.
module running_min_max_mean_unit #(
	parameter int SAMPLE_BITS = rmmm_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = rmmm_pkg::DEF_COUNT_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	rmmm_in_if.sink    samples,
	rmmm_out_if.source stats
);
	import rmmm_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	state_t state_q;
	state_t state_next;

	// Statistics state.
	logic        [COUNT_BITS-1:0]  smp_cnt_q;
	logic        [COUNT_BITS-1:0]  tick_cnt_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic signed [SAMPLE_BITS-1:0] total_q;
	logic                          init_q;
	logic                          smp_item_q;

	// Output register.
	logic out_valid_q;

	// Handshake and control strobes.
	logic in_fire;
	logic in_ready;
	logic out_ld;
	logic mean_ld;
	logic total_ld;
	logic total_zero;
	logic use_smp_den;

	// Sample and saturating sum.
	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [SUM_BITS-1:0]    smp_ext;
	logic signed [SUM_BITS:0]      sum_wide;
	logic signed [SUM_BITS-1:0]    sum_sat;

	// Divider hookup.
	div_ctrl_t                     dctrl;
	div_stat_t                     dstat;
	logic        [COUNT_BITS-1:0]  div_den;
	logic signed [SAMPLE_BITS-1:0] div_quot;

	assign smp      = samples.sample[SAMPLE_BITS-1:0];
	assign smp_ext  = SUM_BITS'(smp);
	assign sum_wide = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(smp_ext);

	// When the two top bits of the wide sum disagree the add overflowed, and
	// the top bit tells which rail to stop at.
	always_comb begin
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
			                              : {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_BITS-1:0];
		end
	end

	assign in_fire = samples.valid && in_ready;

	// Next-state logic of the sequencer.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					state_next = samples.has_sample ? ST_ACT_GO : ST_TOT_GO;
				end
			end
			ST_ACT_GO: begin
				state_next = ST_ACT_WAIT;
			end
			ST_ACT_WAIT: begin
				if (dstat.done) begin
					state_next = ST_TOT_GO;
				end
			end
			ST_TOT_GO: begin
				state_next = (tick_cnt_q == '0) ? ST_DONE : ST_TOT_WAIT;
			end
			ST_TOT_WAIT: begin
				if (dstat.done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || stats.ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		in_ready    = 1'b0;
		dctrl.start = 1'b0;
		use_smp_den = 1'b0;
		mean_ld     = 1'b0;
		total_ld    = 1'b0;
		total_zero  = 1'b0;
		out_ld      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_ACT_GO: begin
				dctrl.start = 1'b1;
				use_smp_den = 1'b1;
			end
			ST_ACT_WAIT: begin
				mean_ld = dstat.done;
			end
			ST_TOT_GO: begin
				dctrl.start = (tick_cnt_q != '0);
				total_zero  = (tick_cnt_q == '0);
			end
			ST_TOT_WAIT: begin
				total_ld = dstat.done;
			end
			ST_DONE: begin
				out_ld = !out_valid_q || stats.ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign div_den = use_smp_den ? smp_cnt_q : tick_cnt_q;

	rmmm_div #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dctrl),
		.num    (sum_q),
		.den    (div_den),
		.stat   (dstat),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smp_cnt_q   <= '0;
			tick_cnt_q  <= '0;
			sum_q       <= '0;
			min_q       <= SMP_MAX;
			max_q       <= SMP_MIN;
			mean_q      <= '0;
			total_q     <= '0;
			init_q      <= 1'b0;
			smp_item_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (in_fire) begin
				smp_item_q <= samples.has_sample;
				if (samples.has_sample) begin
					if (smp_cnt_q != '1) begin
						smp_cnt_q <= smp_cnt_q + 1'b1;
					end
					sum_q  <= sum_sat;
					init_q <= 1'b1;
					if (smp < min_q) begin
						min_q <= smp;
					end
					if (smp > max_q) begin
						max_q <= smp;
					end
				end
				if (samples.tick && (tick_cnt_q != '1)) begin
					tick_cnt_q <= tick_cnt_q + 1'b1;
				end
			end
			if (mean_ld) begin
				mean_q <= div_quot;
			end
			if (total_ld) begin
				total_q <= div_quot;
			end else if (total_zero) begin
				total_q <= '0;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (stats.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The stats payload is a snapshot taken when the item is finished.
	always_ff @(posedge clk) begin
		if (out_ld) begin
			stats.sample_count   <= DATA_BITS'(smp_cnt_q);
			stats.tick_count     <= DATA_BITS'(tick_cnt_q);
			stats.running_sum    <= sum_q;
			stats.min_value      <= DATA_BITS'(min_q);
			stats.max_value      <= DATA_BITS'(max_q);
			stats.active_average <= DATA_BITS'(mean_q);
			stats.total_average  <= DATA_BITS'(total_q);
			stats.has_data       <= init_q;
		end
	end

	assign samples.ready = in_ready;
	assign stats.valid   = out_valid_q;

	// Once any sample has arrived, min never exceeds max.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (min_q <= max_q))
		else $error("min above max after a sample");

	// The data flag and a nonzero sample count go together.
	a_init_count: assert property (@(posedge clk) disable iff (!arst_n)
		init_q == (smp_cnt_q != '0))
		else $error("has_data disagrees with sample count");

	// The divider only runs while the sequencer waits for it.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> (state_q == ST_ACT_WAIT || state_q == ST_TOT_WAIT))
		else $error("divider busy outside a wait state");

	// An item with a sample always passes through the active-average division.
	a_act_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOT_GO && $past(state_q) == ST_IDLE) |-> !smp_item_q)
		else $error("sample item skipped the active average");

	// With no ticks counted the total average is zero.
	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && tick_cnt_q == '0) |-> (total_q == '0))
		else $error("total average nonzero without ticks");

endmodule

// ===== verif/tb_running_min_max_mean_unit.sv =====
`timescale 1ns / 100ps

module tb_running_min_max_mean_unit;
	import rmmm_pkg::*;

	// The block is built with its default widths, and the predictor below
	// follows the same widths.
	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	localparam int COUNT_BITS  = DEF_COUNT_BITS;

	localparam longint          SMP_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint          SMP_MIN = -SMP_MAX - 1;
	localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

	// Take the slowest item and add the longest sender gap and the longest
	// receiver stall, and the whole run still fits many times over in this
	// limit.
	localparam int RANDOM_ITEMS  = 1080;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 150;

	// One input item, plus a flag that makes the sender wait until every
	// outstanding stats item has come back before it presents this one.
	typedef struct {
		logic [DATA_BITS-1:0] sample;
		logic                 has_sample;
		logic                 tick;
		bit                   drain_first;
	} item_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] sample_count;
		logic [DATA_BITS-1:0] tick_count;
		logic [SUM_BITS-1:0]  running_sum;
		logic [DATA_BITS-1:0] min_value;
		logic [DATA_BITS-1:0] max_value;
		logic [DATA_BITS-1:0] active_average;
		logic [DATA_BITS-1:0] total_average;
		logic                 has_data;
	} stats_t;

	logic clk;
	logic arst_n;

	rmmm_in_if  samples_if ();
	rmmm_out_if stats_if ();

	running_min_max_mean_unit #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.stats  (stats_if)
	);

	// Items waiting to be sent, and the stats items we still expect back,
	// oldest first.
	item_t  queued_items[$];
	stats_t awaited_stats[$];

	int items_accepted;
	int results_checked;
	int mismatches = 0;
	int cycles = 0;

	int gap_left;
	int stall_left;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	// Running statistics as the block should hold them after each item.
	longint unsigned n_samples = 0;
	longint unsigned n_ticks   = 0;
	longint          acc_sum   = 0;
	longint          lowest    = SMP_MAX;
	longint          highest   = SMP_MIN;
	longint          mean      = 0;
	bit              seen_sample = 1'b0;

	// The sum clamps at both ends of the signed 64-bit range instead of
	// wrapping around.
	function automatic longint saturating_add(longint a, longint b);
		logic [64:0] w;
		w = {a[63], a} + {b[63], b};
		if (w[64] != w[63])
			return w[64] ? longint'(64'h8000_0000_0000_0000) : longint'(64'h7FFF_FFFF_FFFF_FFFF);
		return longint'(w[63:0]);
	endfunction

	// Division truncates toward zero, so it is done on the magnitude. The
	// quotient is then clamped to the sample range, and a zero divisor gives 0.
	function automatic longint clamped_quotient(longint num, longint unsigned den);
		logic [63:0] mag;
		logic [63:0] q;
		if (den == 0)
			return 0;
		mag = (num < 0) ? 64'd0 - num : num;
		q = mag / den;
		if (num < 0) begin
			if (q > 64'(SMP_MAX) + 1)
				return SMP_MIN;
			return -longint'(q);
		end
		if (q > 64'(SMP_MAX))
			return SMP_MAX;
		return longint'(q);
	endfunction

	// Applies one accepted item to the running statistics and returns the
	// stats item that the block should send for it.
	function automatic stats_t fold_item(item_t it);
		longint v;
		longint tot;
		stats_t s;
		if (it.has_sample) begin
			v = longint'($signed(it.sample[SAMPLE_BITS-1:0]));
			if (n_samples < CNT_MAX)
				n_samples++;
			acc_sum = saturating_add(acc_sum, v);
			if (v > highest)
				highest = v;
			if (v < lowest)
				lowest = v;
			mean = clamped_quotient(acc_sum, n_samples);
			seen_sample = 1'b1;
		end
		if (it.tick && n_ticks < CNT_MAX)
			n_ticks++;
		tot = clamped_quotient(acc_sum, n_ticks);
		s.sample_count   = n_samples[DATA_BITS-1:0];
		s.tick_count     = n_ticks[DATA_BITS-1:0];
		s.running_sum    = acc_sum;
		s.min_value      = lowest[DATA_BITS-1:0];
		s.max_value      = highest[DATA_BITS-1:0];
		s.active_average = mean[DATA_BITS-1:0];
		s.total_average  = tot[DATA_BITS-1:0];
		s.has_data       = seen_sample;
		return s;
	endfunction

	task automatic report_mismatch(string what, int idx, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("[%0t] stats item %0d: %s got %h, expected %h", $realtime, idx, what, got, want);
	endtask

	task automatic check_stats(stats_t got, stats_t want, int idx);
		if (got.sample_count !== want.sample_count)
			report_mismatch("sample_count", idx, 64'(got.sample_count),
				64'(want.sample_count));
		if (got.tick_count !== want.tick_count)
			report_mismatch("tick_count", idx, 64'(got.tick_count), 64'(want.tick_count));
		if (got.running_sum !== want.running_sum)
			report_mismatch("running_sum", idx, got.running_sum, want.running_sum);
		if (got.min_value !== want.min_value)
			report_mismatch("min_value", idx, 64'(got.min_value), 64'(want.min_value));
		if (got.max_value !== want.max_value)
			report_mismatch("max_value", idx, 64'(got.max_value), 64'(want.max_value));
		if (got.active_average !== want.active_average)
			report_mismatch("active_average", idx, 64'(got.active_average),
				64'(want.active_average));
		if (got.total_average !== want.total_average)
			report_mismatch("total_average", idx, 64'(got.total_average),
				64'(want.total_average));
		if (got.has_data !== want.has_data)
			report_mismatch("has_data", idx, 64'(got.has_data), 64'(want.has_data));
	endtask

	// A quiet side never idles. Otherwise it draws a fresh random wait for each item, which may also be zero.
	function automatic int wait_cycles(bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 13));
	endfunction

	// Sample values mix fully random words, which exercise every bit, with
	// small values, whole Q16.16 numbers and the two ends of the range.
	function automatic logic [DATA_BITS-1:0] draw_sample();
		logic [DATA_BITS-1:0] r;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				return $urandom;
			end
			4, 5: begin
				return DATA_BITS'(int'($urandom_range(0, 2000)) - 1000);
			end
			6: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			7: begin
				return {16'(int'($urandom_range(0, 200)) - 100), 16'h0000};
			end
			default: begin
				r = $urandom >> $urandom_range(1, 31);
				return $urandom_range(0, 1) ? -r : r;
			end
		endcase
	endfunction

	function automatic void add_item(logic [DATA_BITS-1:0] sample, logic has_sample, logic tick,
		bit drain_first);
		item_t it;
		it.sample      = sample;
		it.has_sample  = has_sample;
		it.tick        = tick;
		it.drain_first = drain_first;
		queued_items.push_back(it);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver. It presents the next queued item once the gap drawn for it has
	// passed. Valid stays high from one item to the next when there is no gap,
	// and the prediction is made at the edge where an item is accepted.
	always @(posedge clk or negedge arst_n) begin : drive_items
		int gap;
		int accepted_now;
		item_t it;
		item_t nxt;
		if (!arst_n) begin
			samples_if.valid      <= 1'b0;
			samples_if.sample     <= '0;
			samples_if.has_sample <= 1'b0;
			samples_if.tick       <= 1'b0;
			gap_left              <= 0;
			items_accepted        <= 0;
		end else begin
			accepted_now = items_accepted;
			gap = gap_left;
			if (samples_if.valid && samples_if.ready) begin
				it.sample      = samples_if.sample;
				it.has_sample  = samples_if.has_sample;
				it.tick        = samples_if.tick;
				it.drain_first = 1'b0;
				awaited_stats.push_back(fold_item(it));
				accepted_now++;
				items_accepted <= accepted_now;
				if ($urandom_range(0, 39) == 0)
					send_quiet = !send_quiet;
				gap = wait_cycles(send_quiet);
			end
			if (samples_if.valid && !samples_if.ready) begin
				// The item on the bus has not been taken yet, so hold it.
			end else if (gap > 0) begin
				samples_if.valid <= 1'b0;
				gap_left <= gap - 1;
			end else if (queued_items.size() != 0 &&
					!(queued_items[0].drain_first && accepted_now != results_checked)) begin
				nxt = queued_items.pop_front();
				samples_if.sample     <= nxt.sample;
				samples_if.has_sample <= nxt.has_sample;
				samples_if.tick       <= nxt.tick;
				samples_if.valid      <= 1'b1;
				gap_left              <= 0;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	// Monitor. Every stats item taken from the block is compared with the
	// oldest prediction. After each one the receiver draws a stall, so ready
	// also drops while the block is still busy dividing.
	always @(posedge clk or negedge arst_n) begin : collect_stats
		stats_t got;
		int s;
		if (!arst_n) begin
			stats_if.ready  <= 1'b0;
			stall_left      <= 0;
			results_checked <= 0;
		end else begin
			if (stats_if.valid && stats_if.ready) begin
				got.sample_count   = stats_if.sample_count;
				got.tick_count     = stats_if.tick_count;
				got.running_sum    = stats_if.running_sum;
				got.min_value      = stats_if.min_value;
				got.max_value      = stats_if.max_value;
				got.active_average = stats_if.active_average;
				got.total_average  = stats_if.total_average;
				got.has_data       = stats_if.has_data;
				if (results_checked == items_accepted) begin
					report_mismatch("unexpected item, none pending", results_checked,
						got.running_sum, '0);
				end else begin
					check_stats(got, awaited_stats.pop_front(), results_checked);
					results_checked <= results_checked + 1;
				end
				if ($urandom_range(0, 39) == 0)
					recv_quiet = !recv_quiet;
				s = wait_cycles(recv_quiet);
				if (s == 0) begin
					stats_if.ready <= 1'b1;
				end else begin
					stats_if.ready <= 1'b0;
					stall_left <= s - 1;
				end
			end else if (!stats_if.ready) begin
				if (stall_left == 0)
					stats_if.ready <= 1'b1;
				else
					stall_left <= stall_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : run_control
		int i;
		// Directed items. The first ones run with no tick counted yet, so the
		// total average must read 0, and the very first item carries neither a
		// sample nor a tick, so min, max and the averages show their reset
		// values. A sample field with has_sample low must be ignored.
		add_item(32'h0000_0000, 1'b0, 1'b0, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
		add_item(32'h8000_0000, 1'b1, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		// Small negative sums check that both averages truncate toward zero.
		add_item(32'hFFFF_FFFD, 1'b1, 1'b1, 1'b0);
		add_item(32'h0000_0000, 1'b1, 1'b0, 1'b0);
		add_item(32'h0000_0001, 1'b1, 1'b1, 1'b0);
		add_item(32'h8000_0000, 1'b1, 1'b1, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
		add_item(32'h0001_0000, 1'b1, 1'b1, 1'b0);
		add_item(32'hFFFF_0000, 1'b1, 1'b1, 1'b0);
		add_item(32'h5555_5555, 1'b1, 1'b0, 1'b0);
		add_item(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0);
		add_item(32'h0000_0000, 1'b0, 1'b1, 1'b0);
		add_item(32'h1234_5678, 1'b0, 1'b1, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);

		// Random items. The first one waits until the directed part has fully
		// drained, and now and then another one does the same.
		for (i = 0; i < RANDOM_ITEMS; i++)
			add_item(draw_sample(), $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)),
				i == 0 || $urandom_range(0, 99) == 0);

		@(posedge arst_n);
		// Sample at the falling edge so the drivers' updates at the rising
		// edge have settled.
		@(negedge clk);
		while (queued_items.size() != 0 || samples_if.valid || results_checked != items_accepted)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rmmm_pkg.sv
rtl/rmmm_if.sv
rtl/rmmm_div.sv
rtl/running_min_max_mean_unit.sv
verif/tb_running_min_max_mean_unit.sv
